[sv/hrsp_pkg.sv]
package hrsp_pkg;

    // default width of the Content-Length accumulator
    localparam int unsigned LENGTH_BITS_DEF = 31;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_UP_D  = 8'h44;
    localparam logic [7:0] CH_UP_G  = 8'h47;
    localparam logic [7:0] CH_UP_P  = 8'h50;

    // part tags
    localparam logic [2:0] PART_DELIM    = 3'd0;
    localparam logic [2:0] PART_METHOD   = 3'd1;
    localparam logic [2:0] PART_PATH     = 3'd2;
    localparam logic [2:0] PART_QUERY    = 3'd3;
    localparam logic [2:0] PART_PROTO    = 3'd4;
    localparam logic [2:0] PART_HDR_NAME = 3'd5;
    localparam logic [2:0] PART_HDR_VAL  = 3'd6;
    localparam logic [2:0] PART_BODY     = 3'd7;

    // method codes
    localparam logic [1:0] METH_NONE   = 2'd0;
    localparam logic [1:0] METH_GET    = 2'd1;
    localparam logic [1:0] METH_POST   = 2'd2;
    localparam logic [1:0] METH_DELETE = 2'd3;

    // status codes
    localparam logic [1:0] STAT_BUSY  = 2'd0;
    localparam logic [1:0] STAT_DONE  = 2'd1;
    localparam logic [1:0] STAT_ERROR = 2'd2;

    // parser states
    localparam logic [3:0] PH_METHOD     = 4'd0;
    localparam logic [3:0] PH_PATH_START = 4'd1;
    localparam logic [3:0] PH_PATH       = 4'd2;
    localparam logic [3:0] PH_QUERY      = 4'd3;
    localparam logic [3:0] PH_PROTO      = 4'd4;
    localparam logic [3:0] PH_LINE_START = 4'd5;
    localparam logic [3:0] PH_NAME       = 4'd6;
    localparam logic [3:0] PH_SKIP       = 4'd7;
    localparam logic [3:0] PH_VALUE      = 4'd8;
    localparam logic [3:0] PH_BODY       = 4'd9;
    localparam logic [3:0] PH_AFTER      = 4'd10;
    localparam logic [3:0] PH_ERROR      = 4'd11;

    // header-name match tracker
    typedef struct packed {
        logic [3:0] pos;
        logic       hit;
    } t_name_track;

    // method text including the trailing space; zero past the end
    function automatic logic [7:0] verb_char(input logic [1:0] meth, input logic [2:0] pos);
        logic [7:0] r;
        r = CH_NUL;
        case (meth)
            METH_GET: begin
                case (pos)
                    3'd0: r = "G";
                    3'd1: r = "E";
                    3'd2: r = "T";
                    3'd3: r = " ";
                    default: r = CH_NUL;
                endcase
            end
            METH_POST: begin
                case (pos)
                    3'd0: r = "P";
                    3'd1: r = "O";
                    3'd2: r = "S";
                    3'd3: r = "T";
                    3'd4: r = " ";
                    default: r = CH_NUL;
                endcase
            end
            METH_DELETE: begin
                case (pos)
                    3'd0: r = "D";
                    3'd1: r = "E";
                    3'd2: r = "L";
                    3'd3: r = "E";
                    3'd4: r = "T";
                    3'd5: r = "E";
                    3'd6: r = " ";
                    default: r = CH_NUL;
                endcase
            end
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    // "Content-Length"
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] r;
        case (pos)
            4'd0:  r = "C";
            4'd1:  r = "o";
            4'd2:  r = "n";
            4'd3:  r = "t";
            4'd4:  r = "e";
            4'd5:  r = "n";
            4'd6:  r = "t";
            4'd7:  r = "-";
            4'd8:  r = "L";
            4'd9:  r = "e";
            4'd10: r = "n";
            4'd11: r = "g";
            4'd12: r = "t";
            4'd13: r = "h";
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    // one header-name byte against the tracker; position saturates at 15
    function automatic t_name_track track_name(input t_name_track cur, input logic [7:0] c);
        t_name_track r;
        r = cur;
        if (!(cur.pos < 4'd14 && c == name_char(cur.pos))) r.hit = 1'b0;
        if (cur.pos < 4'd15) r.pos = cur.pos + 4'd1;
        return r;
    endfunction

endpackage

[sv/http_request_stream_parser.sv]
// Channel   Dir  Item                 tdata (low bit up)                         tuser
// s_axis    in   one request byte     ch[7:0]                                    -
// m_axis    out  tagged byte result   byte_out[7:0] method_code[9:8]             part[2:0]
//                                     parse_status[11:10] content_length[42:12]  held_cr[3]
//
// One byte per clock unless the output stalls: the parser state and the result register
// update in the same cycle that a byte is taken, and the result is valid in the next cycle.
// The result register decouples the sides: a byte is taken whenever the result
// register is empty or its item leaves in the same cycle.
// Synchronous active-low reset puts the parser at the start of a request,
// clears the saved Content-Length and empties the result register.
// A stalled output holds its result; no byte is taken until it drains.
module http_request_stream_parser #(
    parameter int unsigned LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // ch[7:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // byte_out[7:0] method_code[9:8] parse_status[11:10] content_length[42:12], zero fill
    output logic [47:0] o_m_axis_tdata,
    output logic [3:0]  o_m_axis_tuser    // part[2:0] held_cr[3]
);

    localparam logic [LENGTH_BITS-1:0] LenMax = '1;

    // parser state
    logic [3:0]             r_phase,   n_phase;
    logic [1:0]             r_method,  n_method;
    logic [2:0]             r_mpos,    n_mpos;
    hrsp_pkg::t_name_track  r_name,    n_name;
    logic                   r_cr,      n_cr;
    logic [LENGTH_BITS-1:0] r_accum,   n_accum;
    logic                   r_digits,  n_digits;
    logic [LENGTH_BITS-1:0] r_saved,   n_saved;

    // result register
    logic       r_valid;
    logic [7:0] r_byte;
    logic [2:0] r_part,   n_part;
    logic       r_held,   n_held;
    logic [1:0] r_mcode;
    logic [1:0] r_status, n_status;
    logic [30:0] r_clen;

    logic       w_take;
    logic [7:0] w_c;
    logic       w_fail, w_done, w_consumed;
    logic       w_restart;
    logic [3:0] w_digit;
    logic [LENGTH_BITS+3:0] w_prod;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_c             = i_s_axis_tdata;

    // accum*10 + digit, with room to detect overflow past the all-ones limit
    assign w_digit = 4'(w_c - hrsp_pkg::CH_ZERO);
    assign w_prod  = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1)
                   + (LENGTH_BITS+4)'(w_digit);

    always_comb begin
        n_phase    = r_phase;
        n_method   = r_method;
        n_mpos     = r_mpos;
        n_name     = r_name;
        n_cr       = r_cr;
        n_accum    = r_accum;
        n_digits   = r_digits;
        n_saved    = r_saved;
        n_part     = hrsp_pkg::PART_DELIM;
        n_held     = 1'b0;
        n_status   = hrsp_pkg::STAT_BUSY;
        w_fail     = 1'b0;
        w_done     = 1'b0;
        w_consumed = 1'b0;
        w_restart  = 1'b0;

        if (r_phase == hrsp_pkg::PH_ERROR) begin
            // swallow up to and including the terminating zero
            n_status = hrsp_pkg::STAT_ERROR;
            if (w_c == hrsp_pkg::CH_NUL) w_restart = 1'b1;
        end else begin
            // resolve a held CR
            if (r_cr) begin
                n_cr = 1'b0;
                if (w_c == hrsp_pkg::CH_LF) begin
                    w_consumed = 1'b1;
                    if (r_phase == hrsp_pkg::PH_LINE_START) begin
                        n_phase = (r_method == hrsp_pkg::METH_POST) ?
                                  hrsp_pkg::PH_BODY : hrsp_pkg::PH_AFTER;
                    end else begin
                        // end of a header value commits a Content-Length
                        if (r_phase != hrsp_pkg::PH_PROTO && r_name.hit) n_saved = r_accum;
                        n_phase    = hrsp_pkg::PH_LINE_START;
                        n_name.pos = 4'd0;
                        n_name.hit = 1'b1;
                    end
                end else begin
                    n_held = 1'b1;
                    // a data CR at line start opens the header name
                    if (r_phase == hrsp_pkg::PH_LINE_START) begin
                        n_name  = hrsp_pkg::track_name(r_name, hrsp_pkg::CH_CR);
                        n_phase = hrsp_pkg::PH_NAME;
                    end
                end
            end

            if (!w_consumed) begin
                if (w_c == hrsp_pkg::CH_NUL) begin
                    if (n_phase == hrsp_pkg::PH_BODY || n_phase == hrsp_pkg::PH_AFTER)
                        w_done = 1'b1;
                    else
                        w_fail = 1'b1;
                end else begin
                    case (n_phase)
                        hrsp_pkg::PH_METHOD: begin
                            if (r_mpos == 3'd0) begin
                                if (w_c == hrsp_pkg::CH_UP_G)      n_method = hrsp_pkg::METH_GET;
                                else if (w_c == hrsp_pkg::CH_UP_P) n_method = hrsp_pkg::METH_POST;
                                else if (w_c == hrsp_pkg::CH_UP_D)
                                    n_method = hrsp_pkg::METH_DELETE;
                                else w_fail = 1'b1;
                            end
                            if (!w_fail) begin
                                if (r_mpos > 3'd6 ||
                                    w_c != hrsp_pkg::verb_char(n_method, r_mpos)) begin
                                    w_fail = 1'b1;
                                end else if (w_c == hrsp_pkg::CH_SPACE) begin
                                    n_phase = hrsp_pkg::PH_PATH_START;
                                end else begin
                                    n_part = hrsp_pkg::PART_METHOD;
                                    n_mpos = r_mpos + 3'd1;
                                end
                            end
                        end
                        hrsp_pkg::PH_PATH_START: begin
                            if (w_c == hrsp_pkg::CH_SLASH) begin
                                n_part  = hrsp_pkg::PART_PATH;
                                n_phase = hrsp_pkg::PH_PATH;
                            end else begin
                                w_fail = 1'b1;
                            end
                        end
                        hrsp_pkg::PH_PATH: begin
                            if (w_c == hrsp_pkg::CH_SPACE)      n_phase = hrsp_pkg::PH_PROTO;
                            else if (w_c == hrsp_pkg::CH_QMARK) n_phase = hrsp_pkg::PH_QUERY;
                            else                                n_part  = hrsp_pkg::PART_PATH;
                        end
                        hrsp_pkg::PH_QUERY: begin
                            if (w_c == hrsp_pkg::CH_SPACE) n_phase = hrsp_pkg::PH_PROTO;
                            else                           n_part  = hrsp_pkg::PART_QUERY;
                        end
                        hrsp_pkg::PH_PROTO: begin
                            if (w_c == hrsp_pkg::CH_CR) n_cr   = 1'b1;
                            else                        n_part = hrsp_pkg::PART_PROTO;
                        end
                        hrsp_pkg::PH_LINE_START, hrsp_pkg::PH_NAME: begin
                            if (n_phase == hrsp_pkg::PH_LINE_START && w_c == hrsp_pkg::CH_CR) begin
                                n_cr = 1'b1;
                            end else if (w_c == hrsp_pkg::CH_COLON) begin
                                n_name.hit = n_name.hit && (n_name.pos == 4'd14);
                                n_phase    = hrsp_pkg::PH_SKIP;
                            end else begin
                                n_part  = hrsp_pkg::PART_HDR_NAME;
                                n_name  = hrsp_pkg::track_name(n_name, w_c);
                                n_phase = hrsp_pkg::PH_NAME;
                            end
                        end
                        hrsp_pkg::PH_SKIP: begin
                            n_phase  = hrsp_pkg::PH_VALUE;
                            n_accum  = '0;
                            n_digits = 1'b1;
                        end
                        hrsp_pkg::PH_VALUE: begin
                            if (w_c == hrsp_pkg::CH_CR) begin
                                n_cr     = 1'b1;
                                n_digits = 1'b0;
                            end else begin
                                n_part = hrsp_pkg::PART_HDR_VAL;
                                if (r_digits && w_c >= hrsp_pkg::CH_ZERO &&
                                    w_c <= hrsp_pkg::CH_NINE) begin
                                    if (w_prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                                        n_accum = LenMax;
                                    else
                                        n_accum = w_prod[LENGTH_BITS-1:0];
                                end else begin
                                    n_digits = 1'b0;
                                end
                            end
                        end
                        hrsp_pkg::PH_BODY: begin
                            n_part = hrsp_pkg::PART_BODY;
                        end
                        default: begin
                            w_fail = 1'b1;
                        end
                    endcase
                end
            end

            if (w_fail) begin
                n_part   = hrsp_pkg::PART_DELIM;
                n_status = hrsp_pkg::STAT_ERROR;
                if (w_c == hrsp_pkg::CH_NUL) begin
                    w_restart = 1'b1;
                end else begin
                    n_phase = hrsp_pkg::PH_ERROR;
                    n_cr    = 1'b0;
                end
            end else if (w_done) begin
                n_status  = hrsp_pkg::STAT_DONE;
                w_restart = 1'b1;
            end
        end
    end

    // parser state; saved length survives a new request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hrsp_pkg::PH_METHOD;
            r_method   <= hrsp_pkg::METH_NONE;
            r_mpos     <= 3'd0;
            r_name.pos <= 4'd0;
            r_name.hit <= 1'b1;
            r_cr       <= 1'b0;
            r_accum    <= '0;
            r_digits   <= 1'b1;
            r_saved    <= '0;
        end else if (w_take) begin
            r_saved <= n_saved;
            if (w_restart) begin
                r_phase    <= hrsp_pkg::PH_METHOD;
                r_method   <= hrsp_pkg::METH_NONE;
                r_mpos     <= 3'd0;
                r_name.pos <= 4'd0;
                r_name.hit <= 1'b1;
                r_cr       <= 1'b0;
                r_accum    <= '0;
                r_digits   <= 1'b1;
            end else begin
                r_phase  <= n_phase;
                r_method <= n_method;
                r_mpos   <= n_mpos;
                r_name   <= n_name;
                r_cr     <= n_cr;
                r_accum  <= n_accum;
                r_digits <= n_digits;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte   <= w_c;
            r_part   <= n_part;
            r_held   <= n_held;
            r_mcode  <= n_method;
            r_status <= n_status;
            r_clen   <= 31'(n_saved);
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {5'd0, r_clen, r_status, r_mcode, r_byte};
    assign o_m_axis_tuser  = {r_held, r_part};

    // an error result never carries a part tag
    a_err_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == hrsp_pkg::STAT_ERROR) |-> (r_part == hrsp_pkg::PART_DELIM))
        else $error("error result with a part tag");

    // completion only on the terminating zero
    a_done_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == hrsp_pkg::STAT_DONE) |-> (r_byte == hrsp_pkg::CH_NUL))
        else $error("completion on a nonzero byte");

    // a byte after a held CR is never the LF of that CR
    a_held_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_held) |-> (r_byte != hrsp_pkg::CH_LF))
        else $error("held CR flagged on an LF");

    // a CR is only held where CR LF can end a line
    a_cr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cr |-> (r_phase == hrsp_pkg::PH_PROTO || r_phase == hrsp_pkg::PH_LINE_START ||
                  r_phase == hrsp_pkg::PH_VALUE))
        else $error("CR held in a wrong state");

    // every taken byte produces a result next cycle
    a_take_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_valid)
        else $error("taken byte lost");

endmodule
